/* rtl/fngs_pkg.sv */
// ----------------------------------------------------------------------------
// fngs_pkg
// Shared types and constants for the four-neighbour grid sum block.
// ----------------------------------------------------------------------------
package fngs_pkg;

  localparam int MAX_SIDE = 256;
  localparam int IDX_W    = $clog2(MAX_SIDE);
  localparam int SIZE_W   = 9;

  localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = 9'd256;
  localparam logic [SIZE_W-1:0] MAX_SIDE_SZ     = SIZE_W'(MAX_SIDE);

  // request types
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [IDX_W-1:0] idx_t;

  // one classified request, handed from the front to the back
  typedef struct packed {
    logic emit;      // produces a result
    logic wr_en;     // sample goes into the older store
    logic bank;      // 0: store a holds the previous row, 1: store b
    idx_t row;
    idx_t col;
    logic up_en;
    logic left_en;
    logic right_en;
    logic last;
  } fngs_cmd_t;

endpackage

/* rtl/fngs_front.sv */
// ----------------------------------------------------------------------------
// fngs_front
// Holds the grid size and raster position, classifies each request and
// builds the command for the back end.
// ----------------------------------------------------------------------------
module fngs_front import fngs_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [SIZE_W-1:0]       cfg_wr_data,
  input  logic                    in_valid,
  input  logic                    in_req_type,
  input  logic [SAMPLE_WIDTH-1:0] in_pixel_value,
  input  logic                    q_full,
  output logic                    push,
  output fngs_cmd_t               push_cmd,
  output logic [SAMPLE_WIDTH-1:0] push_sample
);

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] row_r, row_nxt;
  idx_t              col_r, col_nxt;
  logic              bank_r, bank_nxt;

  logic [SIZE_W-1:0] n_eff;
  logic              wrap;
  logic [SIZE_W-1:0] row_e;
  idx_t              col_e;
  logic [SIZE_W-1:0] row_m1;
  logic [SIZE_W-1:0] col_inc;
  logic              flushing;

  assign push = in_valid && !q_full;

  always_comb begin
    if (size_r == '0) begin
      n_eff = SIZE_W'(1);
    end else if (size_r > MAX_SIDE_SZ) begin
      n_eff = MAX_SIDE_SZ;
    end else begin
      n_eff = size_r;
    end
  end

  // size may have shrunk below the stored position: restart the frame
  assign wrap     = (row_r > n_eff) || ({1'b0, col_r} >= n_eff);
  assign row_e    = wrap ? '0 : row_r;
  assign col_e    = wrap ? '0 : col_r;
  assign row_m1   = row_e - SIZE_W'(1);
  assign col_inc  = {1'b0, col_e} + SIZE_W'(1);
  assign flushing = (row_e == n_eff);

  always_comb begin
    push_cmd.emit     = (row_e != '0);
    push_cmd.wr_en    = !flushing;
    push_cmd.bank     = bank_r;
    push_cmd.row      = row_m1[IDX_W-1:0];
    push_cmd.col      = col_e;
    push_cmd.up_en    = (row_m1 != '0);
    push_cmd.left_en  = (col_e != '0);
    push_cmd.right_en = (col_inc < n_eff);
    push_cmd.last     = flushing && (col_inc == n_eff);
    push_sample       = (flushing || (in_req_type == REQ_FLUSH)) ? '0 : in_pixel_value;
  end

  always_comb begin
    row_nxt  = row_e;
    col_nxt  = col_inc[IDX_W-1:0];
    bank_nxt = bank_r;
    if (col_inc >= n_eff) begin
      col_nxt = '0;
      if (flushing) begin
        row_nxt = '0;
      end else begin
        row_nxt  = row_e + SIZE_W'(1);
        bank_nxt = !bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= GRID_SIZE_RESET;
      row_r  <= '0;
      col_r  <= '0;
      bank_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      if (push) begin
        row_r  <= row_nxt;
        col_r  <= col_nxt;
        bank_r <= bank_nxt;
      end
    end
  end

endmodule

/* rtl/fngs_queue.sv */
// ----------------------------------------------------------------------------
// fngs_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module fngs_queue import fngs_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  fngs_cmd_t               push_cmd,
  input  logic [SAMPLE_WIDTH-1:0] push_sample,
  output logic                    full,
  output logic                    head_valid,
  output fngs_cmd_t               head_cmd,
  output logic [SAMPLE_WIDTH-1:0] head_sample,
  input  logic                    pop
);

  localparam logic [QPTR_W:0] DEPTH_CNT = (QPTR_W+1)'(QUEUE_DEPTH);

  fngs_cmd_t               cmd_q    [QUEUE_DEPTH];
  logic [SAMPLE_WIDTH-1:0] sample_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r;
  logic [QPTR_W-1:0]       rd_ptr_r;
  logic [QPTR_W:0]         count_r;

  assign full        = (count_r == DEPTH_CNT);
  assign head_valid  = (count_r != '0);
  assign head_cmd    = cmd_q[rd_ptr_r];
  assign head_sample = sample_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr_r]    <= push_cmd;
      sample_q[wr_ptr_r] <= push_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

/* rtl/fngs_back.sv */
// ----------------------------------------------------------------------------
// fngs_back
// Line stores and sum pipeline: reads neighbours, writes the new sample,
// adds the four neighbours and holds the result for the output channel.
// ----------------------------------------------------------------------------
module fngs_back import fngs_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      head_valid,
  input  fngs_cmd_t                 head_cmd,
  input  logic [SAMPLE_WIDTH-1:0]   head_sample,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SAMPLE_WIDTH+1:0]   out_sum_value,
  output logic [IDX_W-1:0]          out_row,
  output logic [IDX_W-1:0]          out_col,
  output logic                      out_last_of_frame
);

  localparam int SUM_W = SAMPLE_WIDTH + 2;

  logic [SAMPLE_WIDTH-1:0] store_a [MAX_SIDE];
  logic [SAMPLE_WIDTH-1:0] store_b [MAX_SIDE];

  logic [SAMPLE_WIDTH-1:0] rd_a0_r, rd_a1_r, rd_b0_r, rd_b1_r;
  logic [SAMPLE_WIDTH-1:0] down_r;
  fngs_cmd_t               b_cmd_r;
  logic                    b_valid_r;
  logic                    out_valid_r;
  logic [SUM_W-1:0]        sum_r;
  idx_t                    row_r, col_r;
  logic                    last_r;

  idx_t addr_a0, addr_b0, addr_hi;
  logic b_adv;

  logic [SAMPLE_WIDTH-1:0] left_raw, right_raw, up_raw;
  logic [SUM_W-1:0]        left_x, right_x, up_x, down_x;
  logic [SUM_W-1:0]        sum_nxt;

  assign b_adv = !out_valid_r || !out_stall;
  assign pop   = head_valid && (!b_valid_r || b_adv);

  // the previous-row store reads both side neighbours, the older one the cell above
  assign addr_hi = head_cmd.col + IDX_W'(1);
  assign addr_a0 = head_cmd.bank ? head_cmd.col : (head_cmd.col - IDX_W'(1));
  assign addr_b0 = head_cmd.bank ? (head_cmd.col - IDX_W'(1)) : head_cmd.col;

  // reads see the store before this request's own write
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_a0_r <= store_a[addr_a0];
      rd_a1_r <= store_a[addr_hi];
      if (head_cmd.wr_en && head_cmd.bank) begin
        store_a[head_cmd.col] <= head_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_b0_r <= store_b[addr_b0];
      rd_b1_r <= store_b[addr_hi];
      if (head_cmd.wr_en && !head_cmd.bank) begin
        store_b[head_cmd.col] <= head_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_cmd_r <= head_cmd;
      down_r  <= head_sample;
    end
  end

  always_comb begin
    left_raw  = b_cmd_r.bank ? rd_b0_r : rd_a0_r;
    right_raw = b_cmd_r.bank ? rd_b1_r : rd_a1_r;
    up_raw    = b_cmd_r.bank ? rd_a0_r : rd_b0_r;
    left_x    = b_cmd_r.left_en  ? {{2{left_raw[SAMPLE_WIDTH-1]}}, left_raw}   : '0;
    right_x   = b_cmd_r.right_en ? {{2{right_raw[SAMPLE_WIDTH-1]}}, right_raw} : '0;
    up_x      = b_cmd_r.up_en    ? {{2{up_raw[SAMPLE_WIDTH-1]}}, up_raw}       : '0;
    down_x    = {{2{down_r[SAMPLE_WIDTH-1]}}, down_r};
    sum_nxt   = left_x + right_x + up_x + down_x;
  end

  always_ff @(posedge clk) begin
    if (b_valid_r && b_adv) begin
      sum_r  <= sum_nxt;
      row_r  <= b_cmd_r.row;
      col_r  <= b_cmd_r.col;
      last_r <= b_cmd_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        b_valid_r <= head_cmd.emit;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sum_value     = sum_r;
  assign out_row           = row_r;
  assign out_col           = col_r;
  assign out_last_of_frame = last_r;

endmodule

/* rtl/four_neighbour_grid_sum.sv */
// ----------------------------------------------------------------------------
// four_neighbour_grid_sum
// Four-neighbour cross sum over a square raster grid with two line stores.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_req_type, in_pixel_value
//   out      output     out_valid/out_stall  out_sum_value, out_row, out_col,
//                                            out_last_of_frame
//   cfg      input      cfg_wr_en            cfg_wr_data (grid size)
//
// one request per clock while in_stall is low; the front classifies requests
// into a two-entry command queue, the back handles one request per cycle in
// the line stores, unless out_stall holds it, and registers the sum; out_stall
// backs up through the queue; in_stall rises once the queue fills
// rst_n (synchronous) clears position, bank and the pipeline and sets the
// grid size to 256; the line stores need no clearing
// ----------------------------------------------------------------------------
module four_neighbour_grid_sum import fngs_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [SIZE_W-1:0]       cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic [SAMPLE_WIDTH-1:0] in_pixel_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_WIDTH+1:0] out_sum_value,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic                    out_last_of_frame
);

  logic                    push, q_full, head_valid, pop;
  fngs_cmd_t               push_cmd, head_cmd;
  logic [SAMPLE_WIDTH-1:0] push_sample, head_sample;

  assign in_stall = q_full;

  fngs_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_req_type    (in_req_type),
    .in_pixel_value (in_pixel_value),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd),
    .push_sample    (push_sample)
  );

  fngs_queue #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_cmd    (push_cmd),
    .push_sample (push_sample),
    .full        (q_full),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .head_sample (head_sample),
    .pop         (pop)
  );

  fngs_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_cmd          (head_cmd),
    .head_sample       (head_sample),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sum_value     (out_sum_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
